/* src/sst_pkg.sv */
// types, codes and constants shared by the stride scheduler slot table
`default_nettype none

package sst_pkg;

    localparam int KIND_W      = 3;
    localparam int SLOT_FIELD_W = 4;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int ID_W        = 32;
    localparam int LIMIT_W     = 16;
    localparam int NUMER_W     = 32;
    localparam int STRIDE_W    = 64;
    localparam int CNT_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam int SLOTS_DEF   = 16;

    localparam logic [PRIO_W-1:0]  PRIO_RESET  = 8'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;
    localparam logic [NUMER_W-1:0] NUMER_RESET = 32'd65536;
    localparam logic [ID_W-1:0]    ID_FIRST    = 32'd1;
    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

    localparam logic [KIND_W-1:0] KIND_ALLOC    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_YIELD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXIT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MKRUN    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SETPRIO  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE_RUN   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_KILLED     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUNNING = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_NUM = 1'd1;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_USED     = 2'd1,
        ST_RUNNABLE = 2'd2,
        ST_RUNNING  = 2'd3
    } t_slot_st;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [PRIO_W-1:0]       new_priority;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] chosen_slot;
        logic [ID_W-1:0]         task_id;
    } t_rsp;

    typedef struct packed {
        logic [CNT_W-1:0]    dispatches;
        logic [STRIDE_W-1:0] stride;
    } t_row;

endpackage

`default_nettype wire

/* src/stride_scheduler_slot_table.sv */
// stride scheduler slot table: slot state, scan sequencer and serial divider
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in  (sst_pkg::t_req)
//  out       output     o_out_valid / i_out_ready  o_out (sst_pkg::t_rsp)
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one transaction at a time; allocate checks the slots in order until a free one, one slot per cycle
//  schedule reads one slot per cycle, then on a dispatch runs a 32-step divider;
//  it ends without the divider when nothing is runnable or on a kill
//  the other kinds answer directly or after one id memory read
//  reset clears control state and per-slot valid bits at once, no clearing pass
//  a result waits in the output register until taken; cfg writes are always taken
`default_nettype none

module stride_scheduler_slot_table #(
    parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire sst_pkg::t_req                 i_in,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output sst_pkg::t_rsp                      o_out,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [sst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [sst_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CMP_W  = (SLOT_W + 1 > sst_pkg::SLOT_FIELD_W) ?
                            SLOT_W + 1 : sst_pkg::SLOT_FIELD_W;
    localparam int DIV_CNT_W = $clog2(sst_pkg::NUMER_W);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(sst_pkg::NUMER_W - 1);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_ALLOC     = 10'b0000000010,
        S_SCAN      = 10'b0000000100,
        S_SCAN_LAST = 10'b0000001000,
        S_PICK      = 10'b0000010000,
        S_COUNT     = 10'b0000100000,
        S_DIV       = 10'b0001000000,
        S_ADD       = 10'b0010000000,
        S_ID        = 10'b0100000000,
        S_OUT       = 10'b1000000000
    } t_fsm;

    // control state
    t_fsm                            r_fsm, n_fsm;
    logic                            r_out_vld, n_out_vld;
    logic                            r_run_vld, n_run_vld;
    logic [SLOT_W-1:0]               r_run_slot, n_run_slot;
    logic [sst_pkg::ID_W-1:0]        r_next_id, n_next_id;
    logic [sst_pkg::LIMIT_W-1:0]     r_run_limit;
    logic [sst_pkg::NUMER_W-1:0]     r_numer;
    sst_pkg::t_slot_st               r_state [SLOTS];
    logic [SLOTS-1:0]                r_row_vld;
    logic [SLOTS-1:0]                r_pri_vld;

    // datapath registers
    sst_pkg::t_rsp                   r_res, n_res;
    logic [SLOT_W-1:0]               r_idx, n_idx;
    logic                            r_pend, n_pend;
    logic [SLOT_W-1:0]               r_cmp_idx, n_cmp_idx;
    logic                            r_found, n_found;
    logic [SLOT_W-1:0]               r_best, n_best;
    logic [sst_pkg::STRIDE_W-1:0]    r_best_stride, n_best_stride;
    logic [sst_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [sst_pkg::STRIDE_W-1:0]    r_stride, n_stride;
    logic [sst_pkg::PRIO_W-1:0]      r_dvs, n_dvs;
    logic [sst_pkg::PRIO_W-1:0]      r_rem, n_rem;
    logic [sst_pkg::NUMER_W-1:0]     r_quo, n_quo;
    logic [DIV_CNT_W-1:0]            r_div_cnt, n_div_cnt;

    // memories and their registered read data
    sst_pkg::t_row                   r_row_mem [SLOTS];
    logic [sst_pkg::PRIO_W-1:0]      r_pri_mem [SLOTS];
    logic [sst_pkg::ID_W-1:0]        r_id_mem  [SLOTS];
    sst_pkg::t_row                   r_row_rd;
    logic [sst_pkg::PRIO_W-1:0]      r_pri_rd;
    logic [sst_pkg::ID_W-1:0]        r_id_rd;
    sst_pkg::t_slot_st               r_st_rd;

    logic [SLOT_W-1:0]               w_addr;
    logic                            w_row_we;
    logic [SLOT_W-1:0]               w_row_wa;
    sst_pkg::t_row                   w_row_wd;
    logic                            w_pri_we;
    logic [SLOT_W-1:0]               w_pri_wa;
    logic                            w_id_we;
    logic [SLOT_W-1:0]               w_id_wa;
    logic                            w_st_we;
    logic [SLOT_W-1:0]               w_st_wa;
    sst_pkg::t_slot_st               w_st_wd;

    logic                            w_in_acc;
    logic                            w_in_range;
    logic [SLOT_W-1:0]               w_in_idx;
    logic [sst_pkg::CNT_W-1:0]       w_cnt_new;
    logic [sst_pkg::PRIO_W:0]        w_trial;
    logic                            w_qbit;
    logic [SLOTS-1:0]                w_is_run;

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_res;
    assign o_cfg_ready = 1'b1;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_in_range = CMP_W'(i_in.slot) < CMP_W'(SLOTS);
    assign w_in_idx   = SLOT_W'(i_in.slot);
    assign w_cnt_new  = (r_row_rd.dispatches == sst_pkg::CNT_MAX) ?
                        r_row_rd.dispatches : r_row_rd.dispatches + 1'b1;
    assign w_trial    = {r_rem, r_quo[sst_pkg::NUMER_W-1]};
    assign w_qbit     = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_is_run[i] = (r_state[i] == sst_pkg::ST_RUNNING);
        end
    end

    always_comb begin
        n_fsm         = r_fsm;
        n_out_vld     = r_out_vld;
        n_run_vld     = r_run_vld;
        n_run_slot    = r_run_slot;
        n_next_id     = r_next_id;
        n_res         = r_res;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_cmp_idx     = r_cmp_idx;
        n_found       = r_found;
        n_best        = r_best;
        n_best_stride = r_best_stride;
        n_cnt         = r_cnt;
        n_stride      = r_stride;
        n_dvs         = r_dvs;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_div_cnt     = r_div_cnt;
        w_addr        = r_best;
        w_row_we      = 1'b0;
        w_row_wa      = r_best;
        w_row_wd      = '{dispatches: w_cnt_new, stride: r_row_rd.stride};
        w_pri_we      = 1'b0;
        w_pri_wa      = w_in_idx;
        w_id_we       = 1'b0;
        w_id_wa       = r_idx;
        w_st_we       = 1'b0;
        w_st_wa       = r_best;
        w_st_wd       = sst_pkg::ST_FREE;

        // running minimum over the slot reads
        if ((r_fsm == S_SCAN || r_fsm == S_SCAN_LAST) && r_pend) begin
            if (r_st_rd == sst_pkg::ST_RUNNABLE &&
                (!r_found || r_row_rd.stride < r_best_stride)) begin
                n_found       = 1'b1;
                n_best        = r_cmp_idx;
                n_best_stride = r_row_rd.stride;
            end
        end

        unique case (r_fsm)
            S_IDLE: begin
                w_addr = w_in_idx;
                if (w_in_acc) begin
                    n_res = '{status: sst_pkg::STATUS_OK, chosen_slot: '0, task_id: '0};
                    unique case (i_in.kind)
                        sst_pkg::KIND_ALLOC: begin
                            n_idx = '0;
                            n_fsm = S_ALLOC;
                        end
                        sst_pkg::KIND_SCHEDULE: begin
                            if (r_run_vld) begin
                                w_st_we = 1'b1;
                                w_st_wa = r_run_slot;
                                w_st_wd = sst_pkg::ST_RUNNABLE;
                            end
                            n_run_vld = 1'b0;
                            n_idx     = '0;
                            n_pend    = 1'b0;
                            n_found   = 1'b0;
                            n_fsm     = S_SCAN;
                        end
                        sst_pkg::KIND_YIELD, sst_pkg::KIND_EXIT: begin
                            if (!r_run_vld) begin
                                n_res.status = sst_pkg::STATUS_NO_RUNNING;
                                n_out_vld    = 1'b1;
                                n_fsm        = S_OUT;
                            end else begin
                                w_addr    = r_run_slot;
                                w_st_we   = 1'b1;
                                w_st_wa   = r_run_slot;
                                w_st_wd   = (i_in.kind == sst_pkg::KIND_YIELD) ?
                                            sst_pkg::ST_RUNNABLE : sst_pkg::ST_FREE;
                                n_run_vld = 1'b0;
                                n_res.chosen_slot = sst_pkg::SLOT_FIELD_W'(r_run_slot);
                                n_fsm     = S_ID;
                            end
                        end
                        sst_pkg::KIND_MKRUN, sst_pkg::KIND_SETPRIO: begin
                            n_res.chosen_slot = i_in.slot;
                            if (!w_in_range) begin
                                n_out_vld = 1'b1;
                                n_fsm     = S_OUT;
                            end else begin
                                if (i_in.kind == sst_pkg::KIND_MKRUN) begin
                                    if (r_state[w_in_idx] == sst_pkg::ST_USED) begin
                                        w_st_we = 1'b1;
                                        w_st_wa = w_in_idx;
                                        w_st_wd = sst_pkg::ST_RUNNABLE;
                                    end
                                end else begin
                                    w_pri_we = (i_in.new_priority != '0);
                                end
                                n_fsm = S_ID;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                            n_fsm     = S_OUT;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (r_state[r_idx] == sst_pkg::ST_FREE) begin
                    w_id_we   = 1'b1;
                    w_st_we   = 1'b1;
                    w_st_wa   = r_idx;
                    w_st_wd   = sst_pkg::ST_USED;
                    n_next_id = r_next_id + 1'b1;
                    n_res     = '{status: sst_pkg::STATUS_OK,
                                  chosen_slot: sst_pkg::SLOT_FIELD_W'(r_idx),
                                  task_id: r_next_id};
                    n_out_vld = 1'b1;
                    n_fsm     = S_OUT;
                end else if (r_idx == LAST) begin
                    n_res.status = sst_pkg::STATUS_NO_FREE;
                    n_out_vld    = 1'b1;
                    n_fsm        = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN: begin
                w_addr    = r_idx;
                n_pend    = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx == LAST) begin
                    n_fsm = S_SCAN_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN_LAST: begin
                n_pend = 1'b0;
                if (n_found) begin
                    n_fsm = S_PICK;
                end else begin
                    n_res.status = sst_pkg::STATUS_NONE_RUN;
                    n_out_vld    = 1'b1;
                    n_fsm        = S_OUT;
                end
            end
            S_PICK: begin
                n_fsm = S_COUNT;
            end
            S_COUNT: begin
                n_res.chosen_slot = sst_pkg::SLOT_FIELD_W'(r_best);
                n_res.task_id     = r_id_rd;
                if (w_cnt_new > r_run_limit) begin
                    w_row_we     = 1'b1;
                    w_st_we      = 1'b1;
                    w_st_wd      = sst_pkg::ST_FREE;
                    n_res.status = sst_pkg::STATUS_KILLED;
                    n_out_vld    = 1'b1;
                    n_fsm        = S_OUT;
                end else begin
                    n_cnt     = w_cnt_new;
                    n_stride  = r_row_rd.stride;
                    n_dvs     = r_pri_rd;
                    n_rem     = '0;
                    n_quo     = r_numer;
                    n_div_cnt = DIV_LAST;
                    n_fsm     = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                n_rem = w_qbit ? sst_pkg::PRIO_W'(w_trial - {1'b0, r_dvs}) :
                                 w_trial[sst_pkg::PRIO_W-1:0];
                n_quo = {r_quo[sst_pkg::NUMER_W-2:0], w_qbit};
                if (r_div_cnt == '0) begin
                    n_fsm = S_ADD;
                end else begin
                    n_div_cnt = r_div_cnt - 1'b1;
                end
            end
            S_ADD: begin
                w_row_we     = 1'b1;
                w_row_wd     = '{dispatches: r_cnt,
                                 stride: r_stride + sst_pkg::STRIDE_W'(r_quo)};
                w_st_we      = 1'b1;
                w_st_wd      = sst_pkg::ST_RUNNING;
                n_run_vld    = 1'b1;
                n_run_slot   = r_best;
                n_res.status = sst_pkg::STATUS_OK;
                n_out_vld    = 1'b1;
                n_fsm        = S_OUT;
            end
            S_ID: begin
                n_res.task_id = r_id_rd;
                n_out_vld     = 1'b1;
                n_fsm         = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_vld = 1'b0;
                    n_fsm     = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_vld   <= 1'b0;
            r_run_vld   <= 1'b0;
            r_next_id   <= sst_pkg::ID_FIRST;
            r_run_limit <= sst_pkg::LIMIT_RESET;
            r_numer     <= sst_pkg::NUMER_RESET;
            r_row_vld   <= '0;
            r_pri_vld   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_state[i] <= sst_pkg::ST_FREE;
            end
        end else begin
            r_fsm     <= n_fsm;
            r_out_vld <= n_out_vld;
            r_run_vld <= n_run_vld;
            r_next_id <= n_next_id;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == sst_pkg::CFG_RUN_LIMIT) begin
                    r_run_limit <= i_cfg_data[sst_pkg::LIMIT_W-1:0];
                end else if (i_cfg_index == sst_pkg::CFG_STRIDE_NUM) begin
                    r_numer <= i_cfg_data[sst_pkg::NUMER_W-1:0];
                end
            end
            if (w_row_we) begin
                r_row_vld[w_row_wa] <= 1'b1;
            end
            if (w_pri_we) begin
                r_pri_vld[w_pri_wa] <= 1'b1;
            end
            if (w_st_we) begin
                r_state[w_st_wa] <= w_st_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_slot    <= n_run_slot;
        r_res         <= n_res;
        r_idx         <= n_idx;
        r_pend        <= n_pend;
        r_cmp_idx     <= n_cmp_idx;
        r_found       <= n_found;
        r_best        <= n_best;
        r_best_stride <= n_best_stride;
        r_cnt         <= n_cnt;
        r_stride      <= n_stride;
        r_dvs         <= n_dvs;
        r_rem         <= n_rem;
        r_quo         <= n_quo;
        r_div_cnt     <= n_div_cnt;
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_row_mem[w_row_wa] <= w_row_wd;
        end
        r_row_rd <= r_row_vld[w_addr] ? r_row_mem[w_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_pri_we) begin
            r_pri_mem[w_pri_wa] <= i_in.new_priority;
        end
        r_pri_rd <= r_pri_vld[w_addr] ? r_pri_mem[w_addr] : sst_pkg::PRIO_RESET;
    end

    always_ff @(posedge i_clk) begin
        if (w_id_we) begin
            r_id_mem[w_id_wa] <= r_next_id;
        end
        r_id_rd <= r_id_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        r_st_rd <= r_state[w_addr];
    end

    a_run_slot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_vld |-> (r_state[r_run_slot] == sst_pkg::ST_RUNNING))
        else $error("running slot not in running state");

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_is_run) <= 1)
        else $error("more than one slot running");

    a_ready_excl_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an accepted transaction");

    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_fsm == S_OUT))
        else $error("result valid outside output state");

endmodule

`default_nettype wire
